// ===== hdl/orthonormal_basis_from_normal_top_assert.svh =====
// ----------------------------------------------------------------------------
// assertion macros for the orthonormal basis block
// ----------------------------------------------------------------------------
`ifndef ORTHONORMAL_BASIS_FROM_NORMAL_TOP_ASSERT_SVH
`define ORTHONORMAL_BASIS_FROM_NORMAL_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define OBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/obn_pkg.sv =====
// ----------------------------------------------------------------------------
// obn_pkg
// types and fixed widths shared by the orthonormal basis pipeline
// ----------------------------------------------------------------------------
package obn_pkg;

  // vector field width
  localparam int VEC_W     = 16;
  // raw tangent component, signed
  localparam int T_W       = 18;
  // tangent magnitude
  localparam int MAG_W     = 17;
  // one squared component and the squared length
  localparam int SQ_W      = 33;
  localparam int SUM_W     = 34;
  // extra fraction bits of the length radicand
  localparam int RAD_SHIFT = 20;
  // root of the length radicand and its remainder
  localparam int ROOT_W    = 27;
  localparam int REM_W     = 28;
  // reciprocal of the length, numerator 2^DIV_EXP
  localparam int DIV_EXP   = 62;
  localparam int RECIP_W   = 53;
  localparam int DIV_INIT  = 1 << (DIV_EXP - RECIP_W);
  // reciprocal split for the partial products
  localparam int RLO_W     = 27;
  localparam int RHI_W     = RECIP_W - RLO_W;
  // tangent product and its fraction position
  localparam int PROD_W    = 71;
  localparam int PROD_SH   = 52;
  localparam logic [MAG_W-1:0] UNIT_MAX = MAG_W'(1) << VEC_W;
  // bitangent scaling width
  localparam int SC_W      = 34;

  typedef struct packed {
    logic signed [VEC_W-1:0] normal_x;
    logic signed [VEC_W-1:0] normal_y;
    logic signed [VEC_W-1:0] normal_z;
  } in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] tangent_x;
    logic signed [VEC_W-1:0] tangent_y;
    logic signed [VEC_W-1:0] tangent_z;
    logic signed [VEC_W-1:0] bitangent_x;
    logic signed [VEC_W-1:0] bitangent_y;
    logic signed [VEC_W-1:0] bitangent_z;
    logic                    degenerate;
  } out_t;

  // request data carried beside the root and reciprocal pipelines
  typedef struct packed {
    in_t                  nrm;
    logic [2:0][T_W-1:0]  t;
    logic                 degen;
  } side_t;

endpackage

// ===== hdl/obn_isqrt.sv =====
// ----------------------------------------------------------------------------
// obn_isqrt
// pipelined integer square root of (rad << RAD_SHIFT), one result bit a stage
// ----------------------------------------------------------------------------
module obn_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [obn_pkg::SUM_W-1:0]  in_rad,
  input  obn_pkg::side_t             in_side,
  output logic                       out_vld,
  output logic [obn_pkg::ROOT_W-1:0] out_root,
  output obn_pkg::side_t             out_side
);
  import obn_pkg::*;

  logic              vld_r  [ROOT_W];
  logic [SUM_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int K = ROOT_W - 1 - g;
    logic              vld_in;
    logic [SUM_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    side_t             side_in;
    logic [1:0]        pair;
    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  sub;
    logic [REM_W+1:0]  diff;
    logic              fits;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    // stage inputs
    if (g == 0) begin : g_head
      assign vld_in  = in_vld;
      assign rad_in  = in_rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld_r[g-1];
      assign rad_in  = rad_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign root_in = root_r[g-1];
      assign side_in = side_r[g-1];
    end

    // next radicand bit pair, low pairs are the zero fill of the shift
    if (2 * K >= RAD_SHIFT) begin : g_pair
      assign pair = rad_in[2*K-RAD_SHIFT+1 : 2*K-RAD_SHIFT];
    end else begin : g_fill
      assign pair = 2'b00;
    end

    // trial subtract
    always_comb begin
      cand     = {rem_in, pair};
      sub      = (REM_W + 2)'({root_in, 2'b01});
      diff     = cand - sub;
      fits     = (cand >= sub);
      rem_nxt  = fits ? diff[REM_W-1:0] : cand[REM_W-1:0];
      root_nxt = {root_in[ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rad_r[g]  <= rad_in;
      rem_r[g]  <= rem_nxt;
      root_r[g] <= root_nxt;
      side_r[g] <= side_in;
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

endmodule

// ===== hdl/obn_recip.sv =====
// ----------------------------------------------------------------------------
// obn_recip
// pipelined restoring divide of 2^DIV_EXP by the length, one quotient bit a stage
// ----------------------------------------------------------------------------
module obn_recip (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_vld,
  input  logic [obn_pkg::ROOT_W-1:0]  in_len,
  input  obn_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [obn_pkg::RECIP_W-1:0] out_recip,
  output obn_pkg::side_t              out_side
);
  import obn_pkg::*;

  logic               vld_r  [RECIP_W];
  logic [ROOT_W-1:0]  len_r  [RECIP_W];
  logic [ROOT_W-1:0]  rem_r  [RECIP_W];
  logic [RECIP_W-1:0] quo_r  [RECIP_W];
  side_t              side_r [RECIP_W];

  for (genvar g = 0; g < RECIP_W; g++) begin : g_stage
    logic               vld_in;
    logic [ROOT_W-1:0]  len_in;
    logic [ROOT_W-1:0]  rem_in;
    logic [RECIP_W-1:0] quo_in;
    side_t              side_in;
    logic [ROOT_W:0]    cand;
    logic [ROOT_W:0]    diff;
    logic               fits;
    logic [ROOT_W-1:0]  rem_nxt;
    logic [RECIP_W-1:0] quo_nxt;

    // stage inputs, the leading numerator bits are folded into the start value
    if (g == 0) begin : g_head
      assign vld_in  = in_vld;
      assign len_in  = in_len;
      assign rem_in  = ROOT_W'(DIV_INIT);
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_body
      assign vld_in  = vld_r[g-1];
      assign len_in  = len_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign side_in = side_r[g-1];
    end

    // shift in a zero numerator bit and try the subtract
    always_comb begin
      cand    = {rem_in, 1'b0};
      diff    = cand - {1'b0, len_in};
      fits    = (cand >= {1'b0, len_in});
      rem_nxt = fits ? diff[ROOT_W-1:0] : cand[ROOT_W-1:0];
      quo_nxt = {quo_in[RECIP_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      len_r[g]  <= len_in;
      rem_r[g]  <= rem_nxt;
      quo_r[g]  <= quo_nxt;
      side_r[g] <= side_in;
    end
  end

  assign out_vld   = vld_r[RECIP_W-1];
  assign out_recip = quo_r[RECIP_W-1];
  assign out_side  = side_r[RECIP_W-1];

endmodule

// ===== hdl/orthonormal_basis_from_normal_top.sv =====
// ----------------------------------------------------------------------------
// orthonormal_basis_from_normal_top
// unit tangent and bitangent from a fixed point normal, fully pipelined
// ----------------------------------------------------------------------------
//  channel  | ports                 | handshake
//  ---------+-----------------------+-------------------------------------
//  input    | start, busy, in_data  | taken when start is high, busy low
//  result   | out_strobe, out_data  | one cycle strobe, no back pressure
//
//  one request is taken every cycle; busy stays low
//  each result passes through the 27-stage square root and the 53-stage
//  reciprocal pipelines
//  synchronous active low reset clears all valid bits, data is not reset
//  the pipeline never stalls, so nothing is held back or repeated
// ----------------------------------------------------------------------------
module orthonormal_basis_from_normal_top #(
  parameter int FRAC_BITS = 14
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  obn_pkg::in_t   in_data,
  output logic           out_strobe,
  output obn_pkg::out_t  out_data
);
  import obn_pkg::*;

  localparam int TAN_SH = PROD_SH - FRAC_BITS;
  localparam int LAT    = 9 + ROOT_W + RECIP_W;
  localparam int LO_W   = MAG_W + RLO_W;
  localparam int HI_W   = MAG_W + RHI_W;
  localparam int P_W    = 2 * VEC_W;
  localparam logic [PROD_W-1:0]      TAN_RND = PROD_W'(1) << (TAN_SH - 1);
  localparam logic signed [SC_W-1:0] BI_RND  = SC_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SC_W-1:0] S16_MAX = SC_W'(32767);
  localparam logic signed [SC_W-1:0] S16_MIN = -SC_W'(32768);

  function automatic logic [MAG_W-1:0] abs_mag(input logic signed [T_W-1:0] v);
    logic signed [T_W-1:0] n;
    n = -v;
    return v[T_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  assign busy = 1'b0;

  // stage a: raw tangent
  logic                    a_vld_r;
  side_t                   a_side_r;
  side_t                   a_side_nxt;
  logic signed [T_W-1:0]   nx, ny, nz;
  logic                    all_eq;

  always_comb begin
    nx     = T_W'(in_data.normal_x);
    ny     = T_W'(in_data.normal_y);
    nz     = T_W'(in_data.normal_z);
    all_eq = (in_data.normal_x == in_data.normal_y) &&
             (in_data.normal_x == in_data.normal_z);
    a_side_nxt       = '0;
    a_side_nxt.nrm   = in_data;
    a_side_nxt.t[0]  = nz - ny;
    a_side_nxt.t[1]  = all_eq ? nx + nz : nx - nz;
    a_side_nxt.t[2]  = all_eq ? -ny - nx : ny - nx;
  end

  // stage b: squares
  logic                  b_vld_r;
  side_t                 b_side_r;
  logic [SQ_W-1:0]       b_sq_r  [3];
  logic [SQ_W-1:0]       b_sq_nxt[3];
  logic signed [2*T_W-1:0] sq_full;

  always_comb begin
    sq_full = '0;
    for (int i = 0; i < 3; i++) begin
      sq_full     = $signed(a_side_r.t[i]) * $signed(a_side_r.t[i]);
      b_sq_nxt[i] = sq_full[SQ_W-1:0];
    end
  end

  // stage c: squared length and zero check
  logic             c_vld_r;
  side_t            c_side_r;
  logic [SUM_W-1:0] c_sum_r;
  logic [SUM_W-1:0] c_sum_nxt;
  side_t            c_side_nxt;

  always_comb begin
    c_sum_nxt        = SUM_W'(b_sq_r[0]) + SUM_W'(b_sq_r[1]) + SUM_W'(b_sq_r[2]);
    c_side_nxt       = b_side_r;
    c_side_nxt.degen = (c_sum_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_side_r <= a_side_nxt;
    b_side_r <= a_side_r;
    b_sq_r   <= b_sq_nxt;
    c_side_r <= c_side_nxt;
    c_sum_r  <= c_sum_nxt;
  end

  // length and its reciprocal
  logic               sq_vld;
  logic [ROOT_W-1:0]  sq_root;
  side_t              sq_side;
  logic               rc_vld;
  logic [RECIP_W-1:0] rc_recip;
  side_t              rc_side;

  obn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (c_vld_r),
    .in_rad   (c_sum_r),
    .in_side  (c_side_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  obn_recip u_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (sq_vld),
    .in_len    (sq_root),
    .in_side   (sq_side),
    .out_vld   (rc_vld),
    .out_recip (rc_recip),
    .out_side  (rc_side)
  );

  // stage m1: partial products of magnitude and reciprocal
  logic             m1_vld_r;
  side_t            m1_side_r;
  logic [LO_W-1:0]  m1_lo_r  [3];
  logic [HI_W-1:0]  m1_hi_r  [3];
  logic [LO_W-1:0]  m1_lo_nxt[3];
  logic [HI_W-1:0]  m1_hi_nxt[3];
  logic [MAG_W-1:0] mag;

  always_comb begin
    mag = '0;
    for (int i = 0; i < 3; i++) begin
      mag          = abs_mag($signed(rc_side.t[i]));
      m1_lo_nxt[i] = LO_W'(mag) * LO_W'(rc_recip[RLO_W-1:0]);
      m1_hi_nxt[i] = HI_W'(mag) * HI_W'(rc_recip[RECIP_W-1:RLO_W]);
    end
  end

  // stage m2: full product, rounding and clamp of the magnitude
  logic              m2_vld_r;
  side_t             m2_side_r;
  logic [MAG_W-1:0]  m2_q_r  [3];
  logic [MAG_W-1:0]  m2_q_nxt[3];
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quo;

  always_comb begin
    prod = '0;
    quo  = '0;
    for (int i = 0; i < 3; i++) begin
      prod = (PROD_W'(m1_hi_r[i]) << RLO_W) + PROD_W'(m1_lo_r[i]) + TAN_RND;
      quo  = prod >> TAN_SH;
      m2_q_nxt[i] = (quo > PROD_W'(UNIT_MAX)) ? UNIT_MAX : quo[MAG_W-1:0];
    end
  end

  // stage m3: sign and saturation of the unit tangent
  logic                    m3_vld_r;
  side_t                   m3_side_r;
  logic [2:0][VEC_W-1:0]   m3_u_r;
  logic [2:0][VEC_W-1:0]   m3_u_nxt;
  logic [MAG_W-1:0]        neg_q;

  always_comb begin
    neg_q = '0;
    for (int i = 0; i < 3; i++) begin
      neg_q = -m2_q_r[i];
      if (m2_side_r.degen) begin
        m3_u_nxt[i] = '0;
      end else if (m2_side_r.t[i][T_W-1]) begin
        m3_u_nxt[i] = (m2_q_r[i] > MAG_W'(32768)) ? 16'h8000 : neg_q[VEC_W-1:0];
      end else begin
        m3_u_nxt[i] = (m2_q_r[i] > MAG_W'(32767)) ? 16'h7fff : m2_q_r[i][VEC_W-1:0];
      end
    end
  end

  // stage x1: cross product terms
  logic                  x1_vld_r;
  logic                  x1_degen_r;
  logic [2:0][VEC_W-1:0] x1_u_r;
  logic signed [P_W-1:0] x1_p_r  [6];
  logic signed [P_W-1:0] x1_p_nxt[6];
  logic signed [P_W-1:0] ux, uy, uz, mx, my, mz;

  always_comb begin
    ux = P_W'($signed(m3_u_r[0]));
    uy = P_W'($signed(m3_u_r[1]));
    uz = P_W'($signed(m3_u_r[2]));
    mx = P_W'(m3_side_r.nrm.normal_x);
    my = P_W'(m3_side_r.nrm.normal_y);
    mz = P_W'(m3_side_r.nrm.normal_z);
    x1_p_nxt[0] = my * uz;
    x1_p_nxt[1] = mz * uy;
    x1_p_nxt[2] = mz * ux;
    x1_p_nxt[3] = mx * uz;
    x1_p_nxt[4] = mx * uy;
    x1_p_nxt[5] = my * ux;
  end

  // stage x2: difference and round to nearest, ties up
  logic                   x2_vld_r;
  logic                   x2_degen_r;
  logic [2:0][VEC_W-1:0]  x2_u_r;
  logic signed [SC_W-1:0] x2_b_r  [3];
  logic signed [SC_W-1:0] x2_b_nxt[3];
  logic signed [SC_W-1:0] dif;

  always_comb begin
    dif = '0;
    for (int i = 0; i < 3; i++) begin
      dif         = SC_W'(x1_p_r[2*i]) - SC_W'(x1_p_r[2*i+1]);
      x2_b_nxt[i] = (dif + BI_RND) >>> FRAC_BITS;
    end
  end

  // stage x3: saturation into the result register
  logic out_strobe_r;
  out_t out_data_r;
  out_t out_data_nxt;
  logic [2:0][VEC_W-1:0] bsat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (x2_b_r[i] > S16_MAX) begin
        bsat[i] = 16'h7fff;
      end else if (x2_b_r[i] < S16_MIN) begin
        bsat[i] = 16'h8000;
      end else begin
        bsat[i] = x2_b_r[i][VEC_W-1:0];
      end
    end
    out_data_nxt.tangent_x   = x2_u_r[0];
    out_data_nxt.tangent_y   = x2_u_r[1];
    out_data_nxt.tangent_z   = x2_u_r[2];
    out_data_nxt.bitangent_x = bsat[0];
    out_data_nxt.bitangent_y = bsat[1];
    out_data_nxt.bitangent_z = bsat[2];
    out_data_nxt.degenerate  = x2_degen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r     <= 1'b0;
      m2_vld_r     <= 1'b0;
      m3_vld_r     <= 1'b0;
      x1_vld_r     <= 1'b0;
      x2_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      m1_vld_r     <= rc_vld;
      m2_vld_r     <= m1_vld_r;
      m3_vld_r     <= m2_vld_r;
      x1_vld_r     <= m3_vld_r;
      x2_vld_r     <= x1_vld_r;
      out_strobe_r <= x2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_side_r  <= rc_side;
    m1_lo_r    <= m1_lo_nxt;
    m1_hi_r    <= m1_hi_nxt;
    m2_side_r  <= m1_side_r;
    m2_q_r     <= m2_q_nxt;
    m3_side_r  <= m2_side_r;
    m3_u_r     <= m3_u_nxt;
    x1_degen_r <= m3_side_r.degen;
    x1_u_r     <= m3_u_r;
    x1_p_r     <= x1_p_nxt;
    x2_degen_r <= x1_degen_r;
    x2_u_r     <= x1_u_r;
    x2_b_r     <= x2_b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // checks
`include "orthonormal_basis_from_normal_top_assert.svh"

  `OBN_ASSERT_IMP(a_latency, out_strobe, $past(start, LAT), "result without request")
  `OBN_ASSERT_IMP(a_degen_zero, out_strobe && out_data.degenerate,
    (out_data.tangent_x == '0) && (out_data.tangent_y == '0) && (out_data.tangent_z == '0) && (out_data.bitangent_x == '0) && (out_data.bitangent_y == '0) && (out_data.bitangent_z == '0),
    "degenerate result with non-zero vectors")
  `OBN_ASSERT_IMP(a_unit_nonzero, out_strobe && !out_data.degenerate,
    (out_data.tangent_x != '0) || (out_data.tangent_y != '0) || (out_data.tangent_z != '0),
    "zero tangent for a non-zero normal")
  `OBN_ASSERT_NXT(a_degen_terms, m3_vld_r && m3_side_r.degen,
    (x1_p_r[0] == '0) && (x1_p_r[1] == '0) && (x1_p_r[2] == '0) && (x1_p_r[3] == '0) && (x1_p_r[4] == '0) && (x1_p_r[5] == '0),
    "cross terms not cleared for a degenerate request")

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// orthonormal basis block: directed and random normals against a local
// fixed point predictor of tangent, bitangent and the degenerate flag
// ----------------------------------------------------------------------------
module testbench;
  import obn_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = 89;
  localparam longint CYCLE_LIMIT = 400000;

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // floor square root, bit by bit
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit component: magnitude times reciprocal, rounded half away from zero
  function automatic longint unit_part(longint t, longint unsigned recip);
    logic [127:0] p;
    longint unsigned q;
    p = 128'(t < 0 ? -t : t) * 128'(recip) + (128'd1 << (51 - FRAC));
    q = 64'(p >> (52 - FRAC));
    if (q > 65536) q = 65536;
    return clamp16(t < 0 ? -longint'(q) : longint'(q));
  endfunction

  // divide by 2^FRAC, nearest with ties up, then clamp
  function automatic longint scale_back(longint v);
    return clamp16((v + (64'sd1 << (FRAC - 1))) >>> FRAC);
  endfunction

  function automatic out_t predict_basis(in_t n);
    longint nx, ny, nz, tx, ty, tz, ux, uy, uz;
    longint unsigned sq, recip;
    out_t r;
    nx = n.normal_x;
    ny = n.normal_y;
    nz = n.normal_z;
    r = '0;
    // all-equal normals take the (-1,1,1) cross product
    if (nx != ny || nx != nz) begin
      tx = nz - ny; ty = nx - nz; tz = ny - nx;
    end else begin
      tx = nz - ny; ty = nx + nz; tz = -ny - nx;
    end
    sq = tx * tx + ty * ty + tz * tz;
    if (sq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    recip = (64'd1 << 62) / root_floor(sq << 20);
    ux = unit_part(tx, recip);
    uy = unit_part(ty, recip);
    uz = unit_part(tz, recip);
    r.tangent_x = 16'(ux);
    r.tangent_y = 16'(uy);
    r.tangent_z = 16'(uz);
    r.bitangent_x = 16'(scale_back(ny * uz - nz * uy));
    r.bitangent_y = 16'(scale_back(nz * ux - nx * uz));
    r.bitangent_z = 16'(scale_back(nx * uy - ny * ux));
    return r;
  endfunction

  // scoreboard: expected bases in request order
  class basis_board;
    out_t pending[$];
    int errors;
    int checked;

    function void note_request(in_t n);
      pending.push_back(predict_basis(n));
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.tangent_x !== want.tangent_x) begin
        $error("tangent_x expected %0d actual %0d", want.tangent_x, got.tangent_x);
        errors++;
      end
      if (got.tangent_y !== want.tangent_y) begin
        $error("tangent_y expected %0d actual %0d", want.tangent_y, got.tangent_y);
        errors++;
      end
      if (got.tangent_z !== want.tangent_z) begin
        $error("tangent_z expected %0d actual %0d", want.tangent_z, got.tangent_z);
        errors++;
      end
      if (got.bitangent_x !== want.bitangent_x) begin
        $error("bitangent_x expected %0d actual %0d", want.bitangent_x,
               got.bitangent_x);
        errors++;
      end
      if (got.bitangent_y !== want.bitangent_y) begin
        $error("bitangent_y expected %0d actual %0d", want.bitangent_y,
               got.bitangent_y);
        errors++;
      end
      if (got.bitangent_z !== want.bitangent_z) begin
        $error("bitangent_z expected %0d actual %0d", want.bitangent_z,
               got.bitangent_z);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate expected %0b actual %0b", want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_strobe;
  in_t in_data;
  out_t out_data;
  basis_board board;
  longint cycles;
  int sent;
  int idle_pct;

  orthonormal_basis_from_normal_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_strobe) board.check_result(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  // one request, with a random idle gap before it
  task automatic send_normal(in_t n);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= n;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(n);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_xyz(int x, int y, int z);
    in_t n;
    n.normal_x = 16'(x);
    n.normal_y = 16'(y);
    n.normal_z = 16'(z);
    send_normal(n);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] random_comp();
    case ($urandom_range(5))
      0: return 16'($urandom_range(1) ? 32767 : -32768);
      1: return 16'($urandom_range(32) - 16);
      2: return 16'($urandom_range(1) ? 16384 : -16384);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    in_t n;
    board = new();
    cycles = 0;
    sent = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: axes, extremes, equal components, zero normal
    send_xyz(0, 0, 0);
    send_xyz(16384, 0, 0);
    send_xyz(0, 16384, 0);
    send_xyz(0, 0, 16384);
    send_xyz(-16384, 0, 0);
    send_xyz(0, 0, -16384);
    send_xyz(32767, 32767, 32767);
    send_xyz(-32768, -32768, -32768);
    send_xyz(1, 1, 1);
    send_xyz(-1, -1, -1);
    send_xyz(9459, 9459, 9459);
    send_xyz(32767, -32768, 0);
    send_xyz(-32768, 32767, -32768);
    send_xyz(32767, 32767, -32768);
    send_xyz(1, 0, 0);
    send_xyz(0, -1, 0);
    send_xyz(-32768, 0, 32767);
    send_xyz(11585, 11585, 0);
    send_xyz(16'hffff, 16'h5555, 16'haaaa);
    send_xyz(16'h5555, 16'haaaa, 16'hffff);
    // hold off until the pipeline has emptied
    drain();

    // random phases with different sender idling
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 65 : (ph == 3) ? 17 : 0;
      for (int i = 0; i < 320; i++) begin
        if ($urandom_range(9) == 0) begin
          n.normal_x = random_comp();
          n.normal_y = n.normal_x;
          n.normal_z = n.normal_x;
        end else begin
          n.normal_x = random_comp();
          n.normal_y = random_comp();
          n.normal_z = random_comp();
        end
        send_normal(n);
      end
    end

    drain();
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d normals, %0d bases checked, including zero and equal-component",
             sent, board.checked);
    $display("cases under no idling and sender idling phases");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
